/* hdl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants for the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_NEG    = 3'd4,
        OP_EQ     = 3'd5,
        OP_REDUCE = 3'd6
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_ZDEN = 2'd1,
        STAT_OVF  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_PREP,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_FIN,
        S_DONE
    } state_t;

    localparam int S_DATA_BITS = 128;
    localparam int S_USER_BITS = 3;
    localparam int M_DATA_BITS = 72;

    // output tdata bit positions
    localparam int M_STATUS_LSB = 64;
    localparam int M_EQUAL_BIT  = 66;

endpackage

`default_nettype wire

/* hdl/rau_alu.sv */
// ----------------------------------------------------------------------------
// rau_alu
// shared add/subtract unit with sign and magnitude of the result
// ----------------------------------------------------------------------------
`default_nettype none

module rau_alu #(
    parameter int WIDTH = 65
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic             sub,
    output logic      [WIDTH-1:0] res,
    output logic                  neg,
    output logic      [WIDTH-1:0] mag
);

    // operands stay below 2**(WIDTH-1), so the top bit is the sign
    assign res = sub ? (a - b) : (a + b);
    assign neg = res[WIDTH-1];
    assign mag = neg ? (~res + WIDTH'(1)) : res;

endmodule

`default_nettype wire

/* hdl/rational_arith_unit.sv */
// ----------------------------------------------------------------------------
// rational_arith_unit
// fraction add, subtract, multiply, divide, negate, compare and reduce
// ----------------------------------------------------------------------------
//
// channel  | direction | tdata (low bit up)                     | tuser
// ---------+-----------+----------------------------------------+---------
// s_axis   | in        | a_num, a_den, b_num, b_den             | op
// m_axis   | out       | res_num, res_den, status, equal, zeros | none
//
// negate, equal and unused codes: no arithmetic, the result passes S_DONE into the output register
// arithmetic ops: products and setup in S_MUL1, S_MUL2 (S_MUL3 and S_SUM for add and
// subtract) and S_PREP, a binary gcd, then two restoring divisions, numerator then
// denominator, each through the one shared subtractor;
// a zero denominator skips the gcd and divisions
// s_tready is high only while the sequencer is idle; a finished result
// waits in the output register while the next item is taken
// asynchronous active-low reset clears the sequencer and the output valid
//
`default_nettype none

module rational_arith_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
    input  wire logic [rau_pkg::S_DATA_BITS-1:0]    s_tdata,
    // op[2:0]
    input  wire logic [rau_pkg::S_USER_BITS-1:0]    s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // res_num[31:0], res_den[63:32], status[65:64], equal[66], zero[71:67]
    output logic [rau_pkg::M_DATA_BITS-1:0]         m_tdata
);

    import rau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int L  = 2 * WORD_BITS;
    localparam int CW = $clog2(L);

    function automatic logic [31:0] sext(input logic [W-1:0] v);
        sext = 32'($signed(v));
    endfunction

    // input decode: low W bits of each field, sign and magnitude
    logic [W-1:0] in_an, in_ad, in_bn, in_bd;
    logic [W-1:0] min_word;
    logic         in_fire;

    assign in_an    = s_tdata[W-1:0];
    assign in_ad    = s_tdata[32+W-1:32];
    assign in_bn    = s_tdata[64+W-1:64];
    assign in_bd    = s_tdata[96+W-1:96];
    assign min_word = {1'b1, {(W-1){1'b0}}};
    assign in_fire  = s_tvalid && s_tready;

    function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
        abs_w = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    state_t state_reg, state_next;

    logic [2:0]   op_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic         an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [L-1:0] n_reg, t_reg, d_reg, x_reg, y_reg, g_reg, q_reg;
    logic         n_neg_reg, t_neg_reg, d_neg_reg;
    logic [L:0]   r_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]  hnum_reg, hden_reg;
    logic [1:0]   hstat_reg;
    logic         heq_reg;
    logic         out_valid_reg;
    logic [M_DATA_BITS-1:0] out_data_reg;

    op_t op_cur;
    assign op_cur = op_t'(op_reg);

    // shared multiplier operands
    logic [W-1:0] mul_x, mul_y;
    logic         mul_neg;
    logic [L-1:0] prod;

    // shared add/subtract unit operands
    logic [L:0] alu_a, alu_b, alu_res, alu_mag;
    logic       alu_sub, alu_neg;

    logic [L:0] div_shift;
    logic       div_last;
    logic       out_free;
    logic       is_addsub;
    logic [L-1:0] top_val;

    assign div_shift = {r_reg[L-1:0], q_reg[L-1]};
    assign div_last  = (cnt_reg == CW'(L - 1));
    assign out_free  = !out_valid_reg || m_tready;
    assign is_addsub = (op_cur == OP_ADD) || (op_cur == OP_SUB);
    assign top_val   = L'(1) << (W - 1);
    assign prod      = L'(mul_x) * L'(mul_y);

    rau_alu #(
        .WIDTH(L + 1)
    ) u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .sub(alu_sub),
        .res(alu_res),
        .neg(alu_neg),
        .mag(alu_mag)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_t'(s_tuser))
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_next = S_MUL1;
                        OP_REDUCE:                      state_next = S_PREP;
                        default:                        state_next = S_DONE;
                    endcase
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = is_addsub ? S_MUL3 : S_PREP;
            S_MUL3: state_next = S_SUM;
            S_SUM:  state_next = S_PREP;
            S_PREP: state_next = (d_reg == '0) ? S_DONE : S_GCD;
            S_GCD:
            begin
                if ((x_reg == '0) || (y_reg == '0))
                    state_next = S_DIVN;
            end
            S_DIVN: if (div_last) state_next = S_DIVD;
            S_DIVD: if (div_last) state_next = S_FIN;
            S_FIN:  state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // shared unit operand selection
    always_comb
    begin
        mul_x   = an_reg;
        mul_y   = bd_reg;
        mul_neg = an_neg_reg ^ bd_neg_reg;
        alu_a   = {1'b0, x_reg};
        alu_b   = {1'b0, y_reg};
        alu_sub = 1'b1;
        case (state_reg)
            S_MUL1:
            begin
                if (op_cur == OP_MUL)
                begin
                    mul_y   = bn_reg;
                    mul_neg = an_neg_reg ^ bn_neg_reg;
                end
            end
            S_MUL2:
            begin
                mul_x = ad_reg;
                if (op_cur == OP_MUL)
                begin
                    mul_y   = bd_reg;
                    mul_neg = ad_neg_reg ^ bd_neg_reg;
                end
                else
                begin
                    mul_y   = bn_reg;
                    mul_neg = ad_neg_reg ^ bn_neg_reg;
                end
            end
            S_MUL3:
            begin
                mul_x   = ad_reg;
                mul_y   = bd_reg;
                mul_neg = ad_neg_reg ^ bd_neg_reg;
            end
            S_SUM:
            begin
                alu_a   = {1'b0, n_reg};
                alu_b   = {1'b0, t_reg};
                alu_sub = n_neg_reg ^ t_neg_reg;
            end
            S_DIVN, S_DIVD:
            begin
                alu_a = div_shift;
                alu_b = {1'b0, g_reg};
            end
            default:
            begin
                alu_sub = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg     <= s_tuser;
                    an_reg     <= abs_w(in_an);
                    ad_reg     <= abs_w(in_ad);
                    bn_reg     <= abs_w(in_bn);
                    bd_reg     <= abs_w(in_bd);
                    an_neg_reg <= in_an[W-1];
                    ad_neg_reg <= in_ad[W-1];
                    bn_neg_reg <= in_bn[W-1];
                    bd_neg_reg <= in_bd[W-1];
                    // reduce works on A directly
                    n_reg      <= L'(abs_w(in_an));
                    n_neg_reg  <= in_an[W-1];
                    d_reg      <= L'(abs_w(in_ad));
                    d_neg_reg  <= in_ad[W-1];
                    case (op_t'(s_tuser))
                        OP_NEG:
                        begin
                            heq_reg <= 1'b0;
                            if ((in_an == min_word) || (in_ad == min_word))
                            begin
                                hstat_reg <= STAT_OVF;
                                hnum_reg  <= '0;
                                hden_reg  <= '0;
                            end
                            else
                            begin
                                hstat_reg <= STAT_OK;
                                hnum_reg  <= sext(W'(0) - in_an);
                                hden_reg  <= sext(W'(0) - in_ad);
                            end
                        end
                        OP_EQ:
                        begin
                            hnum_reg  <= '0;
                            hden_reg  <= '0;
                            hstat_reg <= STAT_OK;
                            heq_reg   <= (in_an == in_bn) && (in_ad == in_bd);
                        end
                        default:
                        begin
                            hnum_reg  <= '0;
                            hden_reg  <= '0;
                            hstat_reg <= STAT_OK;
                            heq_reg   <= 1'b0;
                        end
                    endcase
                end
            end
            S_MUL1:
            begin
                n_reg     <= prod;
                n_neg_reg <= mul_neg;
            end
            S_MUL2:
            begin
                if (is_addsub)
                begin
                    t_reg     <= prod;
                    t_neg_reg <= mul_neg ^ (op_cur == OP_SUB);
                end
                else
                begin
                    d_reg     <= prod;
                    d_neg_reg <= mul_neg;
                end
            end
            S_MUL3:
            begin
                d_reg     <= prod;
                d_neg_reg <= mul_neg;
            end
            S_SUM:
            begin
                // signed-magnitude sum, sign follows the larger part
                if (!alu_sub || !alu_neg)
                    n_reg <= alu_res[L-1:0];
                else
                begin
                    n_reg     <= alu_mag[L-1:0];
                    n_neg_reg <= t_neg_reg;
                end
            end
            S_PREP:
            begin
                if (d_reg == '0)
                    hstat_reg <= STAT_ZDEN;
                x_reg     <= n_reg;
                y_reg     <= d_reg;
                cnt_reg   <= '0;
                n_neg_reg <= (n_reg != '0) && (n_neg_reg != d_neg_reg);
            end
            S_GCD:
            begin
                // binary gcd, common factors of two counted in cnt_reg
                if ((x_reg == '0) || (y_reg == '0))
                begin
                    g_reg   <= (x_reg == '0) ? (y_reg << cnt_reg) : (x_reg << cnt_reg);
                    q_reg   <= n_reg;
                    r_reg   <= '0;
                    cnt_reg <= '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg   <= x_reg >> 1;
                    y_reg   <= y_reg >> 1;
                    cnt_reg <= cnt_reg + CW'(1);
                end
                else if (!x_reg[0])
                    x_reg <= x_reg >> 1;
                else if (!y_reg[0])
                    y_reg <= y_reg >> 1;
                else if (!alu_neg)
                    x_reg <= alu_res[L-1:0];
                else
                    y_reg <= alu_mag[L-1:0];
            end
            S_DIVN, S_DIVD:
            begin
                // restoring division, one quotient bit a cycle
                if (div_last)
                begin
                    cnt_reg <= '0;
                    r_reg   <= '0;
                    if (state_reg == S_DIVN)
                    begin
                        n_reg <= {q_reg[L-2:0], !alu_neg};
                        q_reg <= d_reg;
                    end
                    else
                        d_reg <= {q_reg[L-2:0], !alu_neg};
                end
                else
                begin
                    r_reg   <= alu_neg ? div_shift : alu_res;
                    q_reg   <= {q_reg[L-2:0], !alu_neg};
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            S_FIN:
            begin
                if ((n_neg_reg ? (n_reg > top_val) : (n_reg >= top_val)) ||
                    (d_reg >= top_val))
                    hstat_reg <= STAT_OVF;
                else
                begin
                    hnum_reg <= sext(n_neg_reg ? (~n_reg[W-1:0] + W'(1)) : n_reg[W-1:0]);
                    hden_reg <= sext(d_reg[W-1:0]);
                end
            end
            S_DONE:
            begin
                if (out_free)
                    out_data_reg <= {5'd0, heq_reg, hstat_reg, hden_reg, hnum_reg};
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/rau_checker.sv */
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks on the result channel of the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

module rau_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rau_pkg::M_DATA_BITS-1:0] m_tdata
);

    import rau_pkg::*;

    // stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // status code 3 is never produced
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_STATUS_LSB+1:M_STATUS_LSB] != 2'd3)
        else $error("bad status code");

    // a flagged error carries zero parts
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[M_STATUS_LSB+1:M_STATUS_LSB] != STAT_OK
        |-> m_tdata[63:0] == 64'd0)
        else $error("error result with nonzero parts");

    // equal flag only on a clean compare item
    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[M_EQUAL_BIT]
        |-> m_tdata[63:0] == 64'd0 && m_tdata[M_STATUS_LSB+1:M_STATUS_LSB] == STAT_OK)
        else $error("equal flag with other fields set");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
